[sv/lrp_pkg.sv]
`default_nettype none

package lrp_pkg;

  // table dimensions
  localparam int unsigned NUM_STATES       = 64;
  localparam int unsigned NUM_SYMBOLS      = 128;
  localparam int unsigned NUM_PRODUCTIONS  = 64;
  localparam int unsigned STACK_DEPTH      = 64;
  localparam int unsigned MAX_REDUCE_CHAIN = 15;

  // derived widths
  localparam int unsigned STATE_W   = $clog2(NUM_STATES);
  localparam int unsigned SYM_W     = $clog2(NUM_SYMBOLS);
  localparam int unsigned PROD_W    = $clog2(NUM_PRODUCTIONS);
  localparam int unsigned SIDX_W    = $clog2(STACK_DEPTH);
  localparam int unsigned SP_W      = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CHAIN_W   = $clog2(MAX_REDUCE_CHAIN + 1);
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned TBL_DEPTH = NUM_STATES * NUM_SYMBOLS;
  localparam int unsigned TBL_AW    = $clog2(TBL_DEPTH);
  localparam int unsigned ACT_W     = KIND_W + STATE_W;
  localparam int unsigned GOTO_W    = 1 + STATE_W;
  localparam int unsigned PENT_W    = LEN_W + SYM_W;

  typedef enum logic [1:0] {
    REQ_ACTION = 2'd0,
    REQ_GOTO   = 2'd1,
    REQ_PROD   = 2'd2,
    REQ_PARSE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ACT_ERROR  = 2'd0,
    ACT_SHIFT  = 2'd1,
    ACT_REDUCE = 2'd2,
    ACT_ACCEPT = 2'd3
  } act_kind_e;

  typedef enum logic [1:0] {
    RES_SHIFT  = 2'd0,
    RES_REDUCE = 2'd1,
    RES_ACCEPT = 2'd2,
    RES_ERROR  = 2'd3
  } res_kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACT,
    ST_PROD,
    ST_BELOW,
    ST_GOTO
  } fsm_e;

endpackage

`default_nettype wire

[sv/lrp_in_if.sv]
`default_nettype none

interface lrp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [5:0] state_index;
  logic [6:0] symbol;
  logic [1:0] entry_kind;
  logic [5:0] entry_value;
  logic       goto_valid;
  logic [5:0] prod_index;
  logic [3:0] prod_length;
  logic [6:0] prod_left;

  modport source (
    output valid, req_type, state_index, symbol, entry_kind, entry_value,
           goto_valid, prod_index, prod_length, prod_left,
    input  ready
  );
  modport sink (
    input  valid, req_type, state_index, symbol, entry_kind, entry_value,
           goto_valid, prod_index, prod_length, prod_left,
    output ready
  );
endinterface

`default_nettype wire

[sv/lrp_out_if.sv]
`default_nettype none

interface lrp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [5:0] production;
  logic [5:0] new_state;
  logic [6:0] stack_depth;
  logic       last;

  modport source (
    output valid, result_kind, production, new_state, stack_depth, last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, production, new_state, stack_depth, last,
    output ready
  );
endinterface

`default_nettype wire

[sv/lrp_ram.sv]
`default_nettype none

module lrp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    // read data holds while no read is issued
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

[sv/lr_shift_reduce_parse_engine.sv]
// sequence: a parse beat reads the action entry, and a token that shifts, accepts or fails at
//   once gives its result through the result register; every reduce adds a production read, a
//   stack read and a goto read, then reads the action entry again from the new top
// one token is parsed at a time; table loads one beat per cycle while the sequencer is idle
// reset: stack holds state 0 only; action and goto tables are cleared by a pass over all 8192
//   entries after reset, during which no beat is taken
`default_nettype none

module lr_shift_reduce_parse_engine
  import lrp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lrp_in_if.sink    req_i,
  lrp_out_if.source res_o
);

  // sequencer state
  fsm_e                state_q, state_d;
  logic [TBL_AW-1:0]   clr_q, clr_d;
  logic [SP_W-1:0]     sp_q, sp_d;          // number of stack entries
  logic [STATE_W-1:0]  top_q, top_d;        // cached top of stack
  logic [CHAIN_W-1:0]  chain_q, chain_d;    // reductions made for this token
  logic [SYM_W-1:0]    sym_q, sym_d;        // token being parsed
  logic [PROD_W-1:0]   prod_q, prod_d;      // production under reduction
  logic [LEN_W-1:0]    len_q, len_d;
  logic [SYM_W-1:0]    left_q, left_d;
  logic                below_zero_q, below_zero_d;  // uncovered entry is the stack bottom

  // result register
  logic                out_valid_q;
  logic [1:0]          out_kind_q;
  logic [PROD_W-1:0]   out_prod_q;
  logic [STATE_W-1:0]  out_state_q;
  logic [SP_W-1:0]     out_depth_q;
  logic                out_last_q;

  logic                emit;
  res_kind_e           emit_kind;
  logic [PROD_W-1:0]   emit_prod;
  logic [STATE_W-1:0]  emit_state;
  logic [SP_W-1:0]     emit_depth;
  logic                emit_last;
  logic                out_free;

  // memory ports
  logic                act_we, act_re;
  logic [TBL_AW-1:0]   act_waddr, act_raddr;
  logic [ACT_W-1:0]    act_wdata, act_rdata;
  logic                gto_we, gto_re;
  logic [TBL_AW-1:0]   gto_waddr, gto_raddr;
  logic [GOTO_W-1:0]   gto_wdata, gto_rdata;
  logic                prd_we, prd_re;
  logic [PENT_W-1:0]   prd_rdata;
  logic                stk_we, stk_re;
  logic [SIDX_W-1:0]   stk_waddr, stk_raddr;
  logic [STATE_W-1:0]  stk_wdata, stk_rdata;

  logic                in_beat;
  req_e                req;
  act_kind_e           act_kind;
  logic [STATE_W-1:0]  act_val;
  logic [LEN_W-1:0]    p_len;
  logic [SYM_W-1:0]    p_left;
  logic [STATE_W-1:0]  below;
  logic [SP_W:0]       red_sp;              // depth after a reduce, one bit of headroom
  logic [SP_W-1:0]     pop_sp;              // depth after popping the right side
  logic [SP_W-1:0]     below_idx;

  assign req_i.ready = (state_q == ST_IDLE);
  assign in_beat     = req_i.valid && req_i.ready;
  assign req         = req_e'(req_i.req_type);
  assign out_free    = !out_valid_q || res_o.ready;

  assign act_kind  = act_kind_e'(act_rdata[ACT_W-1 -: KIND_W]);
  assign act_val   = act_rdata[STATE_W-1:0];
  assign p_len     = prd_rdata[PENT_W-1 -: LEN_W];
  assign p_left    = prd_rdata[SYM_W-1:0];
  assign below     = below_zero_q ? '0 : stk_rdata;
  assign pop_sp    = sp_q - SP_W'(len_q);
  assign red_sp    = {1'b0, pop_sp} + (SP_W+1)'(1);
  assign below_idx = sp_q - SP_W'(p_len) - SP_W'(1);

  // table loads go straight to memory; the clearing pass owns both table write ports
  always_comb begin
    act_we    = (state_q == ST_CLEAR) || (in_beat && req == REQ_ACTION);
    act_waddr = (state_q == ST_CLEAR) ? clr_q : {req_i.state_index, req_i.symbol};
    act_wdata = (state_q == ST_CLEAR) ? '0 : {req_i.entry_kind, req_i.entry_value};
    gto_we    = (state_q == ST_CLEAR) || (in_beat && req == REQ_GOTO);
    gto_waddr = act_waddr;
    gto_wdata = (state_q == ST_CLEAR) ? '0 : {req_i.goto_valid, req_i.entry_value};
    prd_we    = in_beat && req == REQ_PROD;
  end

  // sequencer: next state, memory reads, stack writes and results
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    sp_d         = sp_q;
    top_d        = top_q;
    chain_d      = chain_q;
    sym_d        = sym_q;
    prod_d       = prod_q;
    len_d        = len_q;
    left_d       = left_q;
    below_zero_d = below_zero_q;
    act_re       = 1'b0;
    act_raddr    = {top_q, req_i.symbol};
    gto_re       = 1'b0;
    gto_raddr    = {below, left_q};
    prd_re       = 1'b0;
    stk_we       = 1'b0;
    stk_waddr    = sp_q[SIDX_W-1:0];
    stk_wdata    = act_val;
    stk_re       = 1'b0;
    stk_raddr    = below_idx[SIDX_W-1:0];
    emit         = 1'b0;
    emit_kind    = RES_ERROR;
    emit_prod    = '0;
    emit_state   = top_q;
    emit_depth   = sp_q;
    emit_last    = 1'b1;

    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + TBL_AW'(1);
        if (clr_q == TBL_AW'(TBL_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_beat && req == REQ_PARSE) begin
          act_re  = 1'b1;
          sym_d   = req_i.symbol;
          chain_d = '0;
          state_d = ST_ACT;
        end
      end

      ST_ACT: begin
        case (act_kind)
          ACT_SHIFT: begin
            if (out_free) begin
              emit    = 1'b1;
              state_d = ST_IDLE;
              if (sp_q < SP_W'(STACK_DEPTH)) begin
                stk_we     = 1'b1;
                top_d      = act_val;
                sp_d       = sp_q + SP_W'(1);
                emit_kind  = RES_SHIFT;
                emit_state = act_val;
                emit_depth = sp_q + SP_W'(1);
              end
            end
          end
          ACT_ACCEPT: begin
            // the stack bottom always reads as state 0, so no stack write is needed
            if (out_free) begin
              emit       = 1'b1;
              emit_kind  = RES_ACCEPT;
              emit_state = '0;
              emit_depth = SP_W'(1);
              sp_d       = SP_W'(1);
              top_d      = '0;
              state_d    = ST_IDLE;
            end
          end
          ACT_REDUCE: begin
            if (chain_q < CHAIN_W'(MAX_REDUCE_CHAIN)) begin
              prd_re  = 1'b1;
              prod_d  = act_val[PROD_W-1:0];
              state_d = ST_PROD;
            end else if (out_free) begin
              emit    = 1'b1;
              state_d = ST_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              emit    = 1'b1;
              state_d = ST_IDLE;
            end
          end
        endcase
      end

      ST_PROD: begin
        if (SP_W'(p_len) < sp_q) begin
          stk_re       = 1'b1;
          len_d        = p_len;
          left_d       = p_left;
          below_zero_d = (below_idx == '0);
          state_d      = ST_BELOW;
        end else if (out_free) begin
          // stack underflow
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_BELOW: begin
        gto_re  = 1'b1;
        state_d = ST_GOTO;
      end

      ST_GOTO: begin
        if (out_free) begin
          emit = 1'b1;
          if (gto_rdata[GOTO_W-1] && red_sp <= (SP_W+1)'(STACK_DEPTH)) begin
            stk_we     = 1'b1;
            stk_waddr  = pop_sp[SIDX_W-1:0];
            stk_wdata  = gto_rdata[STATE_W-1:0];
            top_d      = gto_rdata[STATE_W-1:0];
            sp_d       = red_sp[SP_W-1:0];
            chain_d    = chain_q + CHAIN_W'(1);
            emit_kind  = RES_REDUCE;
            emit_prod  = prod_q;
            emit_state = gto_rdata[STATE_W-1:0];
            emit_depth = red_sp[SP_W-1:0];
            emit_last  = 1'b0;
            // look again with the same token from the new top
            act_re     = 1'b1;
            act_raddr  = {gto_rdata[STATE_W-1:0], sym_q};
            state_d    = ST_ACT;
          end else begin
            // undefined goto or stack overflow
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      sp_q    <= SP_W'(1);
      top_q   <= '0;
      chain_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      sp_q    <= sp_d;
      top_q   <= top_d;
      chain_q <= chain_d;
    end
  end

  // working registers of the current token
  always_ff @(posedge clk_i) begin
    sym_q        <= sym_d;
    prod_q       <= prod_d;
    len_q        <= len_d;
    left_q       <= left_d;
    below_zero_q <= below_zero_d;
  end

  // result register parts the sequencer from the output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q  <= emit_kind;
      out_prod_q  <= emit_prod;
      out_state_q <= emit_state;
      out_depth_q <= emit_depth;
      out_last_q  <= emit_last;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.result_kind = out_kind_q;
  assign res_o.production  = out_prod_q;
  assign res_o.new_state   = out_state_q;
  assign res_o.stack_depth = out_depth_q;
  assign res_o.last        = out_last_q;

  // memories
  lrp_ram #(.WIDTH(ACT_W), .DEPTH(TBL_DEPTH)) u_action_ram (
    .clk_i   (clk_i),
    .we_i    (act_we),
    .waddr_i (act_waddr),
    .wdata_i (act_wdata),
    .re_i    (act_re),
    .raddr_i (act_raddr),
    .rdata_o (act_rdata)
  );

  lrp_ram #(.WIDTH(GOTO_W), .DEPTH(TBL_DEPTH)) u_goto_ram (
    .clk_i   (clk_i),
    .we_i    (gto_we),
    .waddr_i (gto_waddr),
    .wdata_i (gto_wdata),
    .re_i    (gto_re),
    .raddr_i (gto_raddr),
    .rdata_o (gto_rdata)
  );

  lrp_ram #(.WIDTH(PENT_W), .DEPTH(NUM_PRODUCTIONS)) u_prod_ram (
    .clk_i   (clk_i),
    .we_i    (prd_we),
    .waddr_i (req_i.prod_index),
    .wdata_i ({req_i.prod_length, req_i.prod_left}),
    .re_i    (prd_re),
    .raddr_i (act_val[PROD_W-1:0]),
    .rdata_o (prd_rdata)
  );

  lrp_ram #(.WIDTH(STATE_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // checks
  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q != '0 && sp_q <= SP_W'(STACK_DEPTH))
    else $error("stack pointer out of range");

  a_chain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_q <= CHAIN_W'(MAX_REDUCE_CHAIN))
    else $error("reduce chain beyond bound");

  a_not_last_is_reduce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !emit_last |-> emit_kind == RES_REDUCE)
    else $error("non-final result is not a reduce");

  a_accept_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && emit_kind == RES_ACCEPT |=> sp_q == SP_W'(1) && top_q == '0)
    else $error("accept did not return stack to state 0");

  a_no_beat_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !in_beat)
    else $error("beat taken while sequencer busy");

endmodule

`default_nettype wire
